// File: sv/hufd_pkg.sv
// Package for the Huffman tree byte decoder: opcodes, widths, field offsets
// and the structs passed between the sequencer, step unit and output stage.
// No dependencies.
package hufd_pkg;

   localparam int NODE_BITS   = 8;
   localparam int CHILD_BITS  = 9;
   localparam int LENGTH_BITS = 24;
   localparam int SYM_BITS    = 8;
   localparam int BIT_CNT_BITS = 3;
   localparam int ENTRY_BITS  = 2 * CHILD_BITS;

   localparam logic [NODE_BITS-1:0] ROOT_NODE = 8'd254;

   // Input item kinds carried on req_tuser.
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;

   // Field positions inside req_tdata.
   localparam int NODE_LSB  = 0;
   localparam int ZERO_LSB  = NODE_LSB + NODE_BITS;
   localparam int ONE_LSB   = ZERO_LSB + CHILD_BITS;
   localparam int LEN_LSB   = ONE_LSB + CHILD_BITS;
   localparam int BYTE_LSB  = LEN_LSB + LENGTH_BITS;
   localparam int REQ_TDATA_BITS = 64;

   typedef struct packed {
      logic                   leaf;
      logic [SYM_BITS-1:0]    symbol;
      logic [NODE_BITS-1:0]   next_node;
      logic [LENGTH_BITS-1:0] left_next;
      logic                   last_symbol;
   } step_result_type;

   typedef struct packed {
      logic                valid;
      logic [SYM_BITS-1:0] symbol;
      logic                done;
   } sym_push_type;

   typedef struct packed {
      logic pend_valid;
      logic can_push;
   } out_status_type;

endpackage

// File: sv/hufd_tree_ram.sv
// Node table of the Huffman tree: 256 entries, one write and one registered
// read port. Uses hufd_pkg for widths.
module hufd_tree_ram
   import hufd_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [NODE_BITS-1:0]  wr_addr,
   input  logic [ENTRY_BITS-1:0] wr_data,
   input  logic [NODE_BITS-1:0]  rd_addr,
   output logic [ENTRY_BITS-1:0] rd_data
);

   logic [ENTRY_BITS-1:0] tree_mem_ff [2**NODE_BITS];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hufd_step.sv
// One step of the tree walk: picks the child for the current bit, detects a
// leaf and counts down the symbols left. Uses hufd_pkg.
module hufd_step
   import hufd_pkg::*;
(
   input  logic [ENTRY_BITS-1:0]  node_data,
   input  logic                   bit_in,
   input  logic [LENGTH_BITS-1:0] left,
   output step_result_type        result
);

   logic [CHILD_BITS-1:0] child;

   always_comb begin
      child = bit_in ? node_data[ENTRY_BITS-1:CHILD_BITS] : node_data[CHILD_BITS-1:0];
      result.leaf        = ~child[CHILD_BITS-1];
      result.symbol      = child[SYM_BITS-1:0];
      // A leaf sends the walk back to the root; otherwise follow the pointer.
      result.next_node   = child[CHILD_BITS-1] ? child[NODE_BITS-1:0] : ROOT_NODE;
      result.left_next   = left - LENGTH_BITS'(1);
      result.last_symbol = (left == LENGTH_BITS'(1));
   end

endmodule

// File: sv/hufd_out.sv
// Output stage: a pending symbol register, held until it is known whether it
// is the last of its byte, followed by the result word register. Uses hufd_pkg.
module hufd_out
   import hufd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  sym_push_type        push,
   input  logic                flush,
   output out_status_type      status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   logic                pend_valid_ff, pend_valid_in;
   logic [SYM_BITS-1:0] pend_sym_ff, pend_sym_in;
   logic                pend_done_ff, pend_done_in;
   logic                out_valid_ff, out_valid_in;
   logic [SYM_BITS-1:0] out_sym_ff, out_sym_in;
   logic                out_last_ff, out_last_in;
   logic                out_done_ff, out_done_in;
   logic                can_push;

   assign can_push = ~out_valid_ff | rsp_tready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_sym_in    = out_sym_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      if (push.valid) begin
         // A new symbol proves the pending one is not the last of the byte.
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_sym_in   = pend_sym_ff;
            out_last_in  = 1'b0;
            out_done_in  = pend_done_ff;
         end
         pend_valid_in = 1'b1;
         pend_sym_in   = push.symbol;
         pend_done_in  = push.done;
      end else if (flush && pend_valid_ff && can_push) begin
         out_valid_in  = 1'b1;
         out_sym_in    = pend_sym_ff;
         out_last_in   = 1'b1;
         out_done_in   = pend_done_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      out_sym_ff   <= out_sym_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign status.pend_valid = pend_valid_ff;
   assign status.can_push   = can_push;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

// File: sv/huffman_tree_byte_decoder_unit.sv
// Top level of the Huffman tree byte decoder: sequencer, node table, step
// unit and output stage. Depends on hufd_pkg, hufd_tree_ram, hufd_step, hufd_out.

// The decoder walks a binary Huffman tree held in a 256-node table. A load word
// (req_tuser = 0) writes one node, a start word (req_tuser = 1) sets the number
// of symbols to decode and puts the walk at root node 254, and a data word
// (req_tuser = 2) feeds one compressed byte, least significant bit first. Load
// and start words, and data words while no stream is active, are handled
// without leaving the idle state. A data word of an active stream is accepted
// and then walked one bit at a time, because each bit needs the node read by
// the previous one and the table gives one registered read per cycle. A flush
// state then hands the byte's last symbol to the output register. A byte that
// completes the stream stops walking at that symbol. When a leaf is reached
// while the result register and the pending symbol are both full and the
// downstream side is not taking words, the walk pauses, and the final hand-off
// of the byte waits in the same way.
// req_tready is high only between items.
// Each leaf reached yields one result word: the symbol on rsp_tdata, rsp_tlast
// on the last symbol a byte produces, and rsp_tuser on the symbol that
// completes the requested length, after which remaining bits and bytes are
// ignored until the next start word. Reading a node that was never loaded
// gives an undefined symbol.
module huffman_tree_byte_decoder_unit
   import hufd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits from 0 up: node_index[8], zero_child[9], one_child[9],
   // stream_length[24], data_byte[8], zero fill[6].
   input  logic [63:0] req_tdata,
   // Bits from 0 up: opcode[2].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits from 0 up: symbol[8].
   output logic [7:0]  rsp_tdata,
   // Marks the last symbol that one data byte produces.
   output logic        rsp_tlast,
   // Bits from 0 up: stream_done[1].
   output logic        rsp_tuser
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam logic [BIT_CNT_BITS-1:0] LAST_BIT = '1;

   logic [1:0]              state_ff, state_in;
   logic [NODE_BITS-1:0]    node_ff, node_in;
   logic [LENGTH_BITS-1:0]  left_ff, left_in;
   logic                    active_ff, active_in;
   logic [7:0]              byte_ff, byte_in;
   logic [BIT_CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;

   logic                    req_acc;
   logic                    walking;
   logic                    stall;
   logic                    advance;
   logic                    flush;
   logic [NODE_BITS-1:0]    rd_addr;
   logic [ENTRY_BITS-1:0]   rd_data;
   logic [LENGTH_BITS-1:0]  req_length;
   step_result_type         step;
   sym_push_type            push;
   out_status_type          ost;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign req_length = req_tdata[LEN_LSB +: LENGTH_BITS];

   // The table read issued in one cycle holds the node that the next cycle's
   // bit is applied to. When the walk does not advance, the current node is
   // read again so its entry stays on rd_data.
   assign walking = (state_ff == ST_WALK);
   assign stall   = walking & step.leaf & ost.pend_valid & ~ost.can_push;
   assign advance = walking & ~stall;
   assign rd_addr = advance ? step.next_node : node_ff;
   assign flush   = (state_ff == ST_FLUSH);

   hufd_tree_ram u_ram (
      .clock   (clock),
      .wr_en   (req_acc && (req_tuser == OP_LOAD)),
      .wr_addr (req_tdata[NODE_LSB +: NODE_BITS]),
      .wr_data ({req_tdata[ONE_LSB +: CHILD_BITS], req_tdata[ZERO_LSB +: CHILD_BITS]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hufd_step u_step (
      .node_data (rd_data),
      .bit_in    (byte_ff[bit_cnt_ff]),
      .left      (left_ff),
      .result    (step)
   );

   assign push.valid  = advance & step.leaf;
   assign push.symbol = step.symbol;
   assign push.done   = step.last_symbol;

   hufd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .flush      (flush),
      .status     (ost),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Sequencer: idle between words, one tree step per cycle while walking and not
   // stalled, then a flush state that releases the pending symbol as the last of the byte.
   always_comb begin
      state_in   = state_ff;
      node_in    = node_ff;
      left_in    = left_ff;
      active_in  = active_ff;
      byte_in    = byte_ff;
      bit_cnt_in = bit_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_START) begin
                  node_in   = ROOT_NODE;
                  left_in   = req_length;
                  active_in = (req_length != '0);
               end else if ((req_tuser == OP_DATA) && active_ff) begin
                  byte_in    = req_tdata[BYTE_LSB +: 8];
                  bit_cnt_in = '0;
                  state_in   = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (advance) begin
               node_in    = step.next_node;
               bit_cnt_in = bit_cnt_ff + BIT_CNT_BITS'(1);
               if (step.leaf) begin
                  left_in = step.left_next;
               end
               if (step.leaf && step.last_symbol) begin
                  // The stream is complete; the rest of the byte is dropped.
                  active_in = 1'b0;
                  state_in  = ST_FLUSH;
               end else if (bit_cnt_ff == LAST_BIT) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!ost.pend_valid || ost.can_push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         node_ff    <= ROOT_NODE;
         left_ff    <= '0;
         active_ff  <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         node_ff    <= node_in;
         left_ff    <= left_in;
         active_ff  <= active_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      byte_ff <= byte_in;
   end

   // A stream is active exactly while symbols remain to be decoded.
   a_active_matches_count: assert property (@(posedge clock) disable iff (reset)
      active_ff == (left_ff != '0))
      else $error("stream active flag disagrees with symbol count");

   a_walk_needs_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> active_ff)
      else $error("walking a byte with no active stream");

   a_stall_holds_node: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(node_ff))
      else $error("tree walk moved during an output stall");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ost.pend_valid)
      else $error("symbol left pending after a byte was finished");

   a_done_at_root: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> (node_ff == ROOT_NODE))
      else $error("walk not at the root after the stream completed");

endmodule

// File: bench/huffman_decode_check_pkg.sv
// Expected-symbol bookkeeping for the Huffman tree byte decoder bench: the
// decoded word layout and a class that walks its own copy of the node table.
// Depends on hufd_pkg for opcodes, field offsets and the root node.
package huffman_decode_check_pkg;
   import hufd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_of_byte;
      logic       stream_done;
   } decoded_sym_type;

   class symbol_ledger;
      logic [ENTRY_BITS-1:0]  node_table [256];
      logic [NODE_BITS-1:0]   walk_node;
      logic [LENGTH_BITS-1:0] symbols_left;
      bit                     stream_on;
      decoded_sym_type        symbols_due [$];
      int                     mismatch_count;

      function new();
         walk_node      = ROOT_NODE;
         symbols_left   = '0;
         stream_on      = 1'b0;
         mismatch_count = 0;
      endfunction

      // Applies one accepted input word and queues the symbols it decodes.
      function void predict_symbols(logic [1:0] op, logic [63:0] data);
         logic [ENTRY_BITS-1:0] entry;
         logic [CHILD_BITS-1:0] child;
         logic [7:0]            data_bits;
         decoded_sym_type       sym;
         int                    produced;
         produced  = 0;
         data_bits = data[BYTE_LSB +: 8];
         case (op)
            OP_LOAD: begin
               node_table[data[NODE_LSB +: NODE_BITS]] =
                  {data[ONE_LSB +: CHILD_BITS], data[ZERO_LSB +: CHILD_BITS]};
            end
            OP_START: begin
               symbols_left = data[LEN_LSB +: LENGTH_BITS];
               walk_node    = ROOT_NODE;
               stream_on    = (symbols_left != '0);
            end
            OP_DATA: begin
               for (int b = 0; b < 8 && stream_on; b++) begin
                  entry = node_table[walk_node];
                  child = data_bits[b] ? entry[ENTRY_BITS-1:CHILD_BITS]
                                       : entry[CHILD_BITS-1:0];
                  if (!child[CHILD_BITS-1]) begin
                     symbols_left     = symbols_left - LENGTH_BITS'(1);
                     sym.symbol       = child[7:0];
                     sym.last_of_byte = 1'b0;
                     sym.stream_done  = (symbols_left == '0);
                     symbols_due.push_back(sym);
                     produced++;
                     walk_node = ROOT_NODE;
                     if (sym.stream_done) stream_on = 1'b0;
                  end else begin
                     walk_node = child[NODE_BITS-1:0];
                  end
               end
               if (produced > 0) begin
                  sym = symbols_due.pop_back();
                  sym.last_of_byte = 1'b1;
                  symbols_due.push_back(sym);
               end
            end
            default: ;
         endcase
      endfunction

      // Compares one received word with the oldest symbol still due.
      function void match_symbol(logic [7:0] symbol, logic last_of_byte,
                                 logic stream_done);
         decoded_sym_type due;
         if (symbols_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no word, got symbol %h last %b done %b",
                     $time, symbol, last_of_byte, stream_done);
            return;
         end
         due = symbols_due.pop_front();
         if (due.symbol !== symbol) begin
            mismatch_count++;
            $display("%0t: symbol expected %h, actual %h", $time, due.symbol, symbol);
         end
         if (due.last_of_byte !== last_of_byte) begin
            mismatch_count++;
            $display("%0t: last_of_byte expected %b, actual %b (symbol %h)",
                     $time, due.last_of_byte, last_of_byte, due.symbol);
         end
         if (due.stream_done !== stream_done) begin
            mismatch_count++;
            $display("%0t: stream_done expected %b, actual %b (symbol %h)",
                     $time, due.stream_done, stream_done, due.symbol);
         end
      endfunction
   endclass

endpackage

// File: bench/tb_huffman_tree_byte_decoder_unit.sv
// Bench for huffman_tree_byte_decoder_unit: directed node loads and streams,
// then random trees and byte streams with idling on both sides and one long
// receiver hold-off. Depends on hufd_pkg and huffman_decode_check_pkg.
module tb_huffman_tree_byte_decoder_unit;
   import hufd_pkg::*;
   import huffman_decode_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Opcode value the block must ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   symbol_ledger ledger = new();

   // Internal nodes of the tree currently in use. Every child pointer that
   // the stimulus writes points into this set, and every member is loaded
   // before any data word can walk through it, so the walk never reads a
   // node that was never written.
   logic [7:0] tree_nodes [$];

   int words_sent = 0;
   // While calm is set neither side idles; the sender keeps it up for a
   // stretch of words in the middle of the random part.
   bit calm = 1'b0;
   // Raised by the sender to ask the receiver for its long hold-off.
   bit choke_request = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   huffman_tree_byte_decoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Random content in every field, zero fill on top. The field that an
   // opcode uses is overwritten by the caller, so the unused fields carry
   // noise the block has to ignore.
   function automatic logic [63:0] noisy_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      w[63:BYTE_LSB+8] = '0;
      return w;
   endfunction

   // Presents one word, optionally after a random gap, and waits for the
   // handshake. The word is handed to the ledger at the edge it was taken.
   task automatic send_word(input logic [1:0] op, input logic [63:0] data);
      int gap = 0;
      if (!calm && $urandom_range(99) < 25) gap = $urandom_range(12, 1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.predict_symbols(op, data);
      words_sent++;
      calm = (words_sent >= 200 && words_sent < 260);
   endtask

   task automatic load_node(input logic [7:0] index, input logic [8:0] zero_child,
                            input logic [8:0] one_child);
      logic [63:0] w;
      w = noisy_word();
      w[NODE_LSB +: NODE_BITS] = index;
      w[ZERO_LSB +: CHILD_BITS] = zero_child;
      w[ONE_LSB +: CHILD_BITS]  = one_child;
      send_word(OP_LOAD, w);
   endtask

   task automatic start_stream(input logic [23:0] length);
      logic [63:0] w;
      w = noisy_word();
      w[LEN_LSB +: LENGTH_BITS] = length;
      send_word(OP_START, w);
   endtask

   task automatic send_byte(input logic [7:0] data_bits);
      logic [63:0] w;
      w = noisy_word();
      w[BYTE_LSB +: 8] = data_bits;
      send_word(OP_DATA, w);
   endtask

   // A child is either a leaf with a random symbol or a link to a node of
   // the current tree (node index plus 256).
   function automatic logic [8:0] pick_child(input int leaf_pct);
      if ($urandom_range(99) < leaf_pct) return {1'b0, 8'($urandom)};
      return {1'b1, tree_nodes[$urandom_range(tree_nodes.size() - 1)]};
   endfunction

   // Builds a tree of up to ten internal nodes rooted at the fixed root.
   // Links may form loops; the walk just keeps going around them.
   task automatic build_random_tree();
      int         node_total;
      logic [7:0] index;
      bit         fresh;
      node_total = $urandom_range(10, 1);
      tree_nodes.delete();
      tree_nodes.push_back(ROOT_NODE);
      while (tree_nodes.size() < node_total) begin
         index = 8'($urandom);
         fresh = 1'b1;
         foreach (tree_nodes[k]) if (tree_nodes[k] == index) fresh = 1'b0;
         if (fresh) tree_nodes.push_back(index);
      end
      foreach (tree_nodes[k]) load_node(tree_nodes[k], pick_child(55), pick_child(55));
   endtask

   // Receiver: takes words, idles at random, and once on request holds
   // rsp_tready low for a long stretch so the block backs up.
   initial begin : drain_side
      int hold_left;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) ledger.match_symbol(rsp_tdata, rsp_tlast, rsp_tuser);
         if (choke_request) begin
            choke_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm || $urandom_range(99) >= 25) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
         end
      end
   end

   // Sender: reset, the directed part, the random part, then the wait for
   // the last symbols and the final verdict.
   initial begin : feed_side
      int segment;
      int pick;
      segment = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A data word with no stream running does nothing, and the unused
      // opcode is ignored.
      send_byte(8'hFF);
      send_word(OP_UNUSED, noisy_word());

      // Root: bit 0 is leaf 0, bit 1 links to node 255 (child value 511).
      // Node 255: bit 0 is leaf FF, bit 1 links to node 0.
      // Node 0: bit 0 is leaf 5A, bit 1 links back to the root (value 510).
      load_node(ROOT_NODE, {1'b0, 8'h00}, {1'b1, 8'hFF});
      load_node(8'hFF, {1'b0, 8'hFF}, {1'b1, 8'h00});
      load_node(8'h00, {1'b0, 8'h5A}, {1'b1, ROOT_NODE});

      // A zero length leaves the stream done at once.
      start_stream(24'd0);
      send_byte(8'h00);

      // Three symbols finish the stream inside the byte; the rest of its
      // bits and the next byte are dropped.
      start_stream(24'd3);
      send_byte(8'h00);
      send_byte(8'h00);

      // Longest stream: a byte that only loops through nodes yields nothing,
      // an all-zero byte yields eight symbols, mixed bytes in between.
      start_stream(24'hFFFFFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hB6);
      send_byte(8'h49);

      // Rewriting a node mid-stream takes effect on the next bit.
      load_node(8'hFF, {1'b1, ROOT_NODE}, {1'b0, 8'hC3});
      send_byte(8'h6B);
      send_word(OP_UNUSED, noisy_word());
      send_byte(8'hFE);

      // Length one ends on the first leaf.
      start_stream(24'd1);
      send_byte(8'h02);

      tree_nodes.delete();
      tree_nodes.push_back(ROOT_NODE);
      tree_nodes.push_back(8'hFF);
      tree_nodes.push_back(8'h00);

      // Random part: mostly well-formed streams over fresh trees, plus
      // noise and one stretch of back-pressure.
      while (words_sent < 340) begin
         segment++;
         if (segment == 5) begin
            // Every bit is a leaf, so each byte pushes eight words while the
            // receiver holds off; the block has to stall its input.
            tree_nodes.delete();
            tree_nodes.push_back(ROOT_NODE);
            load_node(ROOT_NODE, {1'b0, 8'($urandom)}, {1'b0, 8'($urandom)});
            start_stream(24'd1000);
            choke_request = 1'b1;
            repeat (24) send_byte(8'($urandom));
         end else if ($urandom_range(99) < 70) begin
            if ($urandom_range(99) < 70) build_random_tree();
            if ($urandom_range(99) < 90) start_stream(24'($urandom_range(30, 1)));
            else start_stream(24'($urandom));
            repeat ($urandom_range(12, 1)) begin
               pick = $urandom_range(99);
               if (pick < 6)
                  load_node(tree_nodes[$urandom_range(tree_nodes.size() - 1)],
                            pick_child(55), pick_child(55));
               else if (pick < 9)
                  send_word(OP_UNUSED, noisy_word());
               else
                  send_byte(8'($urandom));
            end
         end else begin
            pick = $urandom_range(3);
            case (pick)
               0: send_word(OP_UNUSED, noisy_word());
               1: start_stream(24'd0);
               2: send_byte(8'($urandom));
               default: load_node(tree_nodes[$urandom_range(tree_nodes.size() - 1)],
                                  pick_child(55), pick_child(55));
            endcase
         end
      end

      req_tvalid <= 1'b0;
      while (ledger.symbols_due.size() != 0) @(posedge clock);
      // Room for a trailing byte that decodes nothing, or a stray word.
      repeat (40) @(posedge clock);
      if (ledger.mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
sv/hufd_pkg.sv
sv/hufd_tree_ram.sv
sv/hufd_step.sv
sv/hufd_out.sv
sv/huffman_tree_byte_decoder_unit.sv
bench/huffman_decode_check_pkg.sv
bench/tb_huffman_tree_byte_decoder_unit.sv
